// ----- hw/rtl/multiword_schoolbook_multiplier_unit_macros.svh -----
// Assertion macros shared by the multiword multiplier checker.
`ifndef MULTIWORD_SCHOOLBOOK_MULTIPLIER_UNIT_MACROS_SVH
`define MULTIWORD_SCHOOLBOOK_MULTIPLIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MSMUL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msmul: same-cycle property violated");

// Next-cycle implication, disabled during reset.
`define MSMUL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msmul: next-cycle property violated");

`endif

// ----- hw/rtl/msmul_pkg.sv -----
// Shared constants and types of the multiword schoolbook multiplier.
package msmul_pkg;

   localparam int WORD_W        = 32;
   localparam int PROD_W        = 2 * WORD_W;
   localparam int CFG_W         = 6;
   localparam int IDX_W         = 6;
   localparam int REQ_DATA_W    = 2 * WORD_W;
   localparam int RSP_FIELD_W   = WORD_W + IDX_W;
   localparam int RSP_DATA_W    = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_DATA_W - RSP_FIELD_W;
   localparam int MAX_WORDS_DEF = 32;

   // Sequencer phases.
   typedef enum logic [0:0] {
      PH_LOAD = 1'b0,
      PH_RUN  = 1'b1
   } phase_type;

   // Control that travels with one multiply-accumulate slot.
   typedef struct packed {
      logic valid;
      logic row_first;
      logic col_first;
      logic emit;
      logic a_zero;
      logic b_zero;
   } slot_ctl_type;

   // Shift control for the two operand rings.
   typedef struct packed {
      logic a_shift;
      logic b_shift;
      logic from_input;
   } ring_ctl_type;

endpackage

// ----- hw/rtl/msmul_cell.sv -----
// One word cell of a shift chain: holds a word and passes it towards the head.
module msmul_cell (
   input  logic                        clock,
   input  logic                        shift,
   input  logic                        is_tail,
   input  logic [msmul_pkg::WORD_W-1:0] tail_in,
   input  logic [msmul_pkg::WORD_W-1:0] next_in,
   output logic [msmul_pkg::WORD_W-1:0] q
);

   logic [msmul_pkg::WORD_W-1:0] q_ff;
   logic [msmul_pkg::WORD_W-1:0] q_in;

   // The tail cell takes the chain input, every other cell its upper neighbour.
   always_comb begin
      q_in = q_ff;
      if (shift) begin
         q_in = is_tail ? tail_in : next_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

// ----- hw/rtl/msmul_mac.sv -----
// Shared multiply-accumulate unit with carry loop and result output register.
module msmul_mac #(
   parameter int MAX_WORDS = msmul_pkg::MAX_WORDS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [$clog2(MAX_WORDS+1)-1:0]      n_eff,
   input  msmul_pkg::slot_ctl_type             slot_ctl,
   input  logic [msmul_pkg::WORD_W-1:0]        a_head,
   input  logic [msmul_pkg::WORD_W-1:0]        b_head,
   input  logic [msmul_pkg::WORD_W-1:0]        line_head,
   output logic                                step,
   output logic                                line_shift,
   output logic [msmul_pkg::WORD_W-1:0]        line_push,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [msmul_pkg::WORD_W-1:0]        rsp_word,
   output logic [msmul_pkg::IDX_W-1:0]         rsp_index,
   output logic                                rsp_last
);

   localparam int CNT_W = $clog2(MAX_WORDS + 1);

   msmul_pkg::slot_ctl_type            s1_ctl_ff;
   msmul_pkg::slot_ctl_type            s1_ctl_in;
   logic [msmul_pkg::PROD_W-1:0]       mul_ff;
   logic [msmul_pkg::PROD_W-1:0]       mul_in;
   logic [msmul_pkg::WORD_W-1:0]       carry_ff;
   logic [msmul_pkg::WORD_W-1:0]       carry_in;
   logic [msmul_pkg::IDX_W-1:0]        idx_ff;
   logic [msmul_pkg::IDX_W-1:0]        idx_in;
   logic                               out_valid_ff;
   logic                               out_valid_in;
   logic [msmul_pkg::WORD_W-1:0]       out_word_ff;
   logic [msmul_pkg::WORD_W-1:0]       out_word_in;
   logic [msmul_pkg::IDX_W-1:0]        out_idx_ff;
   logic [msmul_pkg::IDX_W-1:0]        out_idx_in;
   logic                               out_last_ff;
   logic                               out_last_in;

   logic [msmul_pkg::WORD_W-1:0]       a_sel;
   logic [msmul_pkg::WORD_W-1:0]       b_sel;
   logic [msmul_pkg::WORD_W-1:0]       addend;
   logic [msmul_pkg::WORD_W-1:0]       carry_use;
   logic [msmul_pkg::PROD_W-1:0]       sum;
   logic [msmul_pkg::IDX_W-1:0]        last_idx;
   logic                               emit;
   logic                               emit_fire;
   logic                               s2_fire;
   logic                               idx_is_last;

   // Stage one: gate the operands and form the partial product.
   always_comb begin
      a_sel     = slot_ctl.a_zero ? '0 : a_head;
      b_sel     = slot_ctl.b_zero ? '0 : b_head;
      mul_in    = {{msmul_pkg::WORD_W{1'b0}}, a_sel} * {{msmul_pkg::WORD_W{1'b0}}, b_sel};
      s1_ctl_in = step ? slot_ctl : s1_ctl_ff;
   end

   // Stage two: add the stored product word and the running carry.
   always_comb begin
      addend    = s1_ctl_ff.row_first ? '0 : line_head;
      carry_use = s1_ctl_ff.col_first ? '0 : carry_ff;
      sum       = mul_ff + {{msmul_pkg::WORD_W{1'b0}}, addend}
                         + {{msmul_pkg::WORD_W{1'b0}}, carry_use};
      emit      = s1_ctl_ff.valid && s1_ctl_ff.emit;
      step      = !(emit && out_valid_ff && !rsp_ready);
      s2_fire   = step && s1_ctl_ff.valid;
      emit_fire = step && emit;
      carry_in  = s2_fire ? sum[msmul_pkg::PROD_W-1:msmul_pkg::WORD_W] : carry_ff;
   end

   // The first column of a row yields a final word, so the line gets a zero there.
   assign line_shift = s2_fire;
   assign line_push  = s1_ctl_ff.col_first ? '0 : sum[msmul_pkg::WORD_W-1:0];

   // Result index and output register.
   always_comb begin
      last_idx     = msmul_pkg::IDX_W'({n_eff, 1'b0} - (CNT_W + 1)'(1));
      idx_is_last  = (idx_ff == last_idx);
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      if (emit_fire) begin
         idx_in       = idx_is_last ? '0 : idx_ff + msmul_pkg::IDX_W'(1);
         out_valid_in = 1'b1;
         out_word_in  = sum[msmul_pkg::WORD_W-1:0];
         out_idx_in   = idx_ff;
         out_last_in  = idx_is_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff    <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_ctl_ff    <= s1_ctl_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (step) begin
         mul_ff <= mul_in;
      end
      carry_ff    <= carry_in;
      out_word_ff <= out_word_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;
   assign rsp_index = out_idx_ff;
   assign rsp_last  = out_last_ff;

endmodule

// ----- hw/rtl/msmul_seq.sv -----
// Load and row/column sequencer that issues one multiply-accumulate slot per step.
module msmul_seq #(
   parameter int MAX_WORDS = msmul_pkg::MAX_WORDS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [$clog2(MAX_WORDS+1)-1:0] n_eff,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           step,
   output msmul_pkg::ring_ctl_type        ring_ctl,
   output msmul_pkg::slot_ctl_type        slot_ctl
);

   localparam int CNT_W = $clog2(MAX_WORDS + 1);

   msmul_pkg::phase_type state_ff;
   msmul_pkg::phase_type state_in;
   logic [CNT_W-1:0]     loaded_ff;
   logic [CNT_W-1:0]     loaded_in;
   logic [CNT_W-1:0]     row_ff;
   logic [CNT_W-1:0]     row_in;
   logic [CNT_W-1:0]     col_ff;
   logic [CNT_W-1:0]     col_in;

   logic [CNT_W-1:0]     n_last;
   logic                 req_fire;
   logic                 issue;
   logic                 drain_row;
   logic                 col_end;

   // The row after the last operand row only drains the upper product words.
   always_comb begin
      n_last    = n_eff - CNT_W'(1);
      req_fire  = req_valid && req_ready;
      issue     = (state_ff == msmul_pkg::PH_RUN) && step;
      drain_row = (row_ff == n_eff);
      col_end   = drain_row ? (col_ff == n_last) : (col_ff == n_eff);
   end

   // Next phase.
   always_comb begin
      state_in = state_ff;
      if (csr_we) begin
         state_in = msmul_pkg::PH_LOAD;
      end else begin
         case (state_ff)
            msmul_pkg::PH_LOAD: begin
               if (req_fire && (loaded_ff == n_last)) begin
                  state_in = msmul_pkg::PH_RUN;
               end
            end
            msmul_pkg::PH_RUN: begin
               if (issue && drain_row && col_end) begin
                  state_in = msmul_pkg::PH_LOAD;
               end
            end
            default: begin
               state_in = msmul_pkg::PH_LOAD;
            end
         endcase
      end
   end

   // Handshake, ring shifts and slot control for each phase.
   always_comb begin
      req_ready           = 1'b0;
      ring_ctl            = '0;
      slot_ctl            = '0;
      slot_ctl.row_first  = (row_ff == '0);
      slot_ctl.col_first  = (col_ff == '0);
      slot_ctl.emit       = (col_ff == '0) || drain_row;
      slot_ctl.a_zero     = drain_row;
      slot_ctl.b_zero     = (col_ff == n_eff);
      case (state_ff)
         msmul_pkg::PH_LOAD: begin
            req_ready           = 1'b1;
            ring_ctl.from_input = 1'b1;
            ring_ctl.a_shift    = req_fire;
            ring_ctl.b_shift    = req_fire;
         end
         msmul_pkg::PH_RUN: begin
            slot_ctl.valid   = 1'b1;
            ring_ctl.a_shift = issue && !drain_row && (col_ff == n_eff);
            ring_ctl.b_shift = issue && (col_ff != n_eff);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Word, row and column counters.
   always_comb begin
      loaded_in = loaded_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      if (csr_we) begin
         loaded_in = '0;
         row_in    = '0;
         col_in    = '0;
      end else begin
         if (req_fire) begin
            loaded_in = (loaded_ff == n_last) ? '0 : loaded_ff + CNT_W'(1);
         end
         if (issue) begin
            if (col_end) begin
               col_in = '0;
               row_in = drain_row ? '0 : row_ff + CNT_W'(1);
            end else begin
               col_in = col_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= msmul_pkg::PH_LOAD;
         loaded_ff <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         loaded_ff <= loaded_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
      end
   end

endmodule

// ----- hw/rtl/multiword_schoolbook_multiplier_unit.sv -----
// Top level: operand rings, product delay line, sequencer and multiply-accumulate unit.
// Loading takes n word pairs, one per transfer; n is the configured word count.
// After the last pair, n rows of n+1 slots and one drain row of n slots pass the single
// shared multiply-accumulate unit, n*(n+2) slots (1088 at 32 words), one per cycle unless
// an output stall holds them; output stalls hold the whole chain. The first product word
// comes from the first slot after the last input transfer, through the product and output
// registers. Reset clears the sequencer to loading and sets the word count register to one.
module multiword_schoolbook_multiplier_unit #(
   parameter int MAX_WORDS = msmul_pkg::MAX_WORDS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [msmul_pkg::CFG_W-1:0]        csr_wr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: a_word[31:0], b_word[63:32].
   input  logic [msmul_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: product_word[31:0], word_index[37:32], zero padding above.
   output logic [msmul_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_WORDS + 1);

   logic [msmul_pkg::CFG_W-1:0]  n_cfg_ff;
   logic [msmul_pkg::CFG_W-1:0]  n_cfg_in;
   logic [CNT_W-1:0]             n_eff;
   logic [CNT_W-1:0]             n_last;

   msmul_pkg::ring_ctl_type      ring_ctl;
   msmul_pkg::slot_ctl_type      slot_ctl;
   logic                         step;
   logic                         line_shift;
   logic [msmul_pkg::WORD_W-1:0] line_push;
   logic [msmul_pkg::WORD_W-1:0] a_tail_in;
   logic [msmul_pkg::WORD_W-1:0] b_tail_in;
   logic [msmul_pkg::WORD_W-1:0] rsp_word;
   logic [msmul_pkg::IDX_W-1:0]  rsp_index;

   logic [msmul_pkg::WORD_W-1:0] a_q [MAX_WORDS];
   logic [msmul_pkg::WORD_W-1:0] b_q [MAX_WORDS];
   logic [msmul_pkg::WORD_W-1:0] p_q [MAX_WORDS];
   logic [MAX_WORDS-1:0]         tail_sel;

   // Word count register; zero counts as one, values above the maximum as the maximum.
   always_comb begin
      n_cfg_in = csr_wr_en ? csr_wr_data : n_cfg_ff;
      if (n_cfg_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (n_cfg_ff > msmul_pkg::CFG_W'(MAX_WORDS)) begin
         n_eff = CNT_W'(MAX_WORDS);
      end else begin
         n_eff = CNT_W'(n_cfg_ff);
      end
      n_last = n_eff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_cfg_ff <= msmul_pkg::CFG_W'(1);
      end else begin
         n_cfg_ff <= n_cfg_in;
      end
   end

   // Operand rings load from the request channel and otherwise rotate.
   assign a_tail_in = ring_ctl.from_input ? req_tdata[msmul_pkg::WORD_W-1:0] : a_q[0];
   assign b_tail_in = ring_ctl.from_input ?
                      req_tdata[msmul_pkg::REQ_DATA_W-1:msmul_pkg::WORD_W] : b_q[0];

   // Three chains of identical cells, MAX_WORDS cells each, with the tail at cell n-1.
   for (genvar k = 0; k < MAX_WORDS; k++) begin : g_chain
      logic [msmul_pkg::WORD_W-1:0] a_next;
      logic [msmul_pkg::WORD_W-1:0] b_next;
      logic [msmul_pkg::WORD_W-1:0] p_next;

      assign tail_sel[k] = (n_last == CNT_W'(k));

      if (k == MAX_WORDS - 1) begin : g_end
         assign a_next = a_tail_in;
         assign b_next = b_tail_in;
         assign p_next = line_push;
      end else begin : g_mid
         assign a_next = a_q[k+1];
         assign b_next = b_q[k+1];
         assign p_next = p_q[k+1];
      end

      msmul_cell u_a_cell (
         .clock   (clock),
         .shift   (ring_ctl.a_shift),
         .is_tail (tail_sel[k]),
         .tail_in (a_tail_in),
         .next_in (a_next),
         .q       (a_q[k])
      );

      msmul_cell u_b_cell (
         .clock   (clock),
         .shift   (ring_ctl.b_shift),
         .is_tail (tail_sel[k]),
         .tail_in (b_tail_in),
         .next_in (b_next),
         .q       (b_q[k])
      );

      msmul_cell u_p_cell (
         .clock   (clock),
         .shift   (line_shift),
         .is_tail (tail_sel[k]),
         .tail_in (line_push),
         .next_in (p_next),
         .q       (p_q[k])
      );
   end

   msmul_seq #(
      .MAX_WORDS (MAX_WORDS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_wr_en),
      .n_eff     (n_eff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .step      (step),
      .ring_ctl  (ring_ctl),
      .slot_ctl  (slot_ctl)
   );

   msmul_mac #(
      .MAX_WORDS (MAX_WORDS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .n_eff      (n_eff),
      .slot_ctl   (slot_ctl),
      .a_head     (a_q[0]),
      .b_head     (b_q[0]),
      .line_head  (p_q[0]),
      .step       (step),
      .line_shift (line_shift),
      .line_push  (line_push),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_word   (rsp_word),
      .rsp_index  (rsp_index),
      .rsp_last   (rsp_tlast)
   );

   // Result packing.
   assign rsp_tdata = {{msmul_pkg::RSP_PAD_W{1'b0}}, rsp_index, rsp_word};

endmodule

// ----- hw/rtl/msmul_checker.sv -----
// Port-level checker for the multiword multiplier and its bind to the top level.
`include "multiword_schoolbook_multiplier_unit_macros.svh"

module msmul_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             csr_wr_en,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [msmul_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast
);

   logic [msmul_pkg::IDX_W-1:0] rsp_index;

   assign rsp_index = rsp_tdata[msmul_pkg::WORD_W +: msmul_pkg::IDX_W];

   // A stalled result keeps its word and end marker.
   `MSMUL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // A product always has at least two words, so word zero is never the last.
   `MSMUL_ASSERT_NOW(a_first_not_last, clock, reset, rsp_tvalid && (rsp_index == '0), !rsp_tlast)

   // Within a product the word index counts up by one per transfer.
   `MSMUL_ASSERT_NEXT(a_index_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, !rsp_tvalid || (rsp_index == $past(rsp_index) + msmul_pkg::IDX_W'(1)))

   // A word count write returns the block to loading operands.
   `MSMUL_ASSERT_NEXT(a_cfg_reload, clock, reset, csr_wr_en, req_tready)

endmodule

bind multiword_schoolbook_multiplier_unit msmul_checker u_checker (.*);

// ----- tb/msmul_product_checker.sv -----
// Checker for the multiword multiplier: predicts every product word and compares results.
module msmul_product_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [msmul_pkg::CFG_W-1:0]        csr_wr_data,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   // Fields from bit 0: a_word[31:0], b_word[63:32].
   input  logic [msmul_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: product_word[31:0], word_index[37:32], zero padding above.
   input  logic [msmul_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                               rsp_tlast,
   output int                                 mismatch_count,
   output int                                 words_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [msmul_pkg::WORD_W-1:0] word;
      logic [msmul_pkg::IDX_W-1:0]  index;
      logic                         last;
   } product_word_type;

   logic [msmul_pkg::CFG_W-1:0]  word_count_reg;
   logic [msmul_pkg::WORD_W-1:0] a_words [msmul_pkg::MAX_WORDS_DEF];
   logic [msmul_pkg::WORD_W-1:0] b_words [msmul_pkg::MAX_WORDS_DEF];
   int                           words_loaded;
   product_word_type             product_words_due [$];

   // All channel activity is sampled at the rising edge.
   always @(posedge clock) begin : watch
      logic [msmul_pkg::WORD_W-1:0] partial_sums [2*msmul_pkg::MAX_WORDS_DEF];
      logic [msmul_pkg::PROD_W-1:0] acc;
      logic [msmul_pkg::WORD_W-1:0] carry;
      product_word_type             seen;
      product_word_type             due;
      int                           n;
      int                           k;

      if (reset) begin
         word_count_reg = 6'd1;
         words_loaded   = 0;
         mismatch_count = 0;
         product_words_due.delete();
      end else begin
         // A register write restarts the load with the new word count.
         if (csr_wr_en) begin
            word_count_reg = csr_wr_data;
            words_loaded   = 0;
         end

         // Result transfer: compare with the oldest predicted word.
         if (rsp_tvalid && rsp_tready) begin
            seen.word  = rsp_tdata[msmul_pkg::WORD_W-1:0];
            seen.index = rsp_tdata[msmul_pkg::WORD_W+msmul_pkg::IDX_W-1:msmul_pkg::WORD_W];
            seen.last  = rsp_tlast;
            if (product_words_due.size() == 0) begin
               $display("%0t: unexpected product word: expected none, %s %h index %0d last %0b",
                        $time, "got word", seen.word, seen.index, seen.last);
               mismatch_count++;
            end else begin
               due = product_words_due.pop_front();
               if (seen != due) begin
                  $display("%0t: product word mismatch: expected word %h index %0d last %0b,",
                           $time, due.word, due.index, due.last);
                  $display("%0t:    got word %h index %0d last %0b",
                           $time, seen.word, seen.index, seen.last);
                  mismatch_count++;
               end
            end
         end

         // Operand transfer: store the word pair; the last pair triggers the product.
         if (req_tvalid && req_tready) begin
            if (word_count_reg == '0)
               n = 1;
            else if (word_count_reg > msmul_pkg::MAX_WORDS_DEF)
               n = msmul_pkg::MAX_WORDS_DEF;
            else
               n = int'(word_count_reg);
            a_words[words_loaded] = req_tdata[msmul_pkg::WORD_W-1:0];
            b_words[words_loaded] = req_tdata[msmul_pkg::REQ_DATA_W-1:msmul_pkg::WORD_W];
            words_loaded++;
            if (words_loaded == n) begin
               words_loaded = 0;
               for (k = 0; k < 2*n; k++)
                  partial_sums[k] = '0;
               // One row of partial products per word of the first operand,
               // with the row carry landing in the word above the row.
               for (int row = 0; row < n; row++) begin
                  carry = '0;
                  for (int col = 0; col < n; col++) begin
                     acc = a_words[row] * b_words[col] + partial_sums[row+col] + carry;
                     partial_sums[row+col] = acc[msmul_pkg::WORD_W-1:0];
                     carry = acc[msmul_pkg::PROD_W-1:msmul_pkg::WORD_W];
                  end
                  partial_sums[row+n] = carry;
               end
               for (k = 0; k < 2*n; k++) begin
                  due.word  = partial_sums[k];
                  due.index = k[msmul_pkg::IDX_W-1:0];
                  due.last  = (k == 2*n - 1);
                  product_words_due.push_back(due);
               end
            end
         end
      end
      words_due = product_words_due.size();
   end

endmodule

// ----- tb/tb.sv -----
// Testbench top: drives operand and register traffic into the multiplier and gives the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [msmul_pkg::WORD_W-1:0] ALL_ONES = '1;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_ITEMS    = 460;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_wr_en;
   logic [msmul_pkg::CFG_W-1:0]      csr_wr_data;
   logic                             req_tvalid;
   logic                             req_tready;
   // Fields from bit 0: a_word[31:0], b_word[63:32].
   logic [msmul_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // Fields from bit 0: product_word[31:0], word_index[37:32], zero padding above.
   logic [msmul_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             rsp_tlast;

   int mismatch_count;
   int words_due;
   int send_idle_pct     = 0;
   int rsp_stall_pct     = 0;
   int hold_off_requests = 0;

   always #5 clock = ~clock;

   multiword_schoolbook_multiplier_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   msmul_product_checker product_check (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .words_due      (words_due)
   );

   // Result side: random back-pressure, plus a long hold-off whenever one is requested.
   initial begin : result_sink
      int holds_served;
      holds_served = 0;
      rsp_tready   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_requests != holds_served) begin
            holds_served++;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Operand words lean towards zero, all ones and single bits.
   function automatic logic [msmul_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return 32'h1 << $urandom_range(msmul_pkg::WORD_W-1);
         default: return $urandom();
      endcase
   endfunction

   // Offer one word pair and hold it until the transfer; returns at a falling edge.
   task automatic offer_pair(input logic [msmul_pkg::WORD_W-1:0] a_word,
                             input logic [msmul_pkg::WORD_W-1:0] b_word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b_word, a_word};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering until every predicted word has come, then let the block settle.
   task automatic await_results();
      req_tvalid <= 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_words(input logic [msmul_pkg::CFG_W-1:0] code);
      await_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Stimulus: directed corner cases first, then random operand sets in paced rounds.
   initial begin : stimulus
      logic [msmul_pkg::CFG_W-1:0] cfg;
      int                          n;
      int                          sets;
      int                          round;
      int                          partial;
      int                          random_items;

      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Single-word operands at the reset word count: zero and full scale.
      offer_pair('0, '0);
      offer_pair(ALL_ONES, ALL_ONES);
      offer_pair(ALL_ONES, 32'h1);
      // A zero word count behaves as one word.
      program_words(6'd0);
      offer_pair(32'h8000_0000, 32'h8000_0001);
      // Two full-scale words, so every carry ripples to the top.
      program_words(6'd2);
      offer_pair(ALL_ONES, ALL_ONES);
      offer_pair(ALL_ONES, ALL_ONES);
      // A write in the middle of a load throws away the words already taken.
      program_words(6'd3);
      offer_pair(32'h1234_5678, 32'h9abc_def0);
      program_words(6'd2);
      offer_pair(32'hffff_0000, 32'h0000_ffff);
      offer_pair('0, ALL_ONES);
      // Four words: full-scale against one.
      program_words(6'd4);
      offer_pair(ALL_ONES, 32'h1);
      repeat (3) offer_pair(ALL_ONES, '0);

      round        = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         // Rotate the pacing of both sides.
         case (round % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_idle_pct = 64; rsp_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct <= 64; end
            default: begin send_idle_pct = 31; rsp_stall_pct <= 31; end
         endcase

         // Word count: mostly small, with the zero and oversized codes now and then.
         if (round == 1) begin
            cfg = 6'd63; n = msmul_pkg::MAX_WORDS_DEF; sets = 1;
         end else if (round == 5) begin
            cfg = 6'd32; n = msmul_pkg::MAX_WORDS_DEF; sets = 1;
         end else if (round == 2 || round == 7) begin
            cfg = 6'd3; n = 3; sets = 6;
         end else begin
            case ($urandom_range(15))
               0: begin cfg = 6'd0; n = 1; end
               1: begin
                  cfg = msmul_pkg::CFG_W'($urandom_range(33, 63));
                  n   = msmul_pkg::MAX_WORDS_DEF;
               end
               2: begin n = $urandom_range(9, 31); cfg = msmul_pkg::CFG_W'(n); end
               default: begin n = $urandom_range(1, 8); cfg = msmul_pkg::CFG_W'(n); end
            endcase
            sets = (n > 8) ? 1 : $urandom_range(2, 6);
         end
         program_words(cfg);

         // Long result hold-off while the sender keeps offering, so the block backs up.
         if (round == 2 || round == 7)
            hold_off_requests <= hold_off_requests + 1;

         for (int s = 0; s < sets; s++) begin
            for (int w = 0; w < n; w++)
               offer_pair(pick_word(), pick_word());
            random_items += n;
            // Some rounds let every product drain before the next operand set.
            if (round % 5 == 3)
               await_results();
         end

         // Now and then a partial load that the next register write discards.
         if (n > 1 && $urandom_range(3) == 0) begin
            partial = $urandom_range(1, n - 1);
            for (int w = 0; w < partial; w++)
               offer_pair(pick_word(), pick_word());
            random_items += partial;
         end
         round++;
      end

      await_results();
      if (mismatch_count == 0)
         $display("PASS multiword_schoolbook_multiplier_unit");
      else
         $display("FAIL multiword_schoolbook_multiplier_unit");
      $finish;
   end

   // Overall time limit.
   initial begin : watchdog
      #(4_000_000);
      $display("FAIL multiword_schoolbook_multiplier_unit");
      $finish;
   end

endmodule
